// ===== sv/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic       CmdAbsorb = 1'b0;
  localparam logic       CmdFinish = 1'b1;
  localparam logic [7:0] PadByte   = 8'h80;

  typedef logic [31:0] word_t;
  typedef word_t state_t [8];

endpackage

// ===== sv/sha_round.sv =====
`timescale 1ns / 1ps
// One compression round plus one message schedule step; the top reuses it 64 times per block.
module sha_round (
  input  sha_pkg::state_t v_i,
  input  sha_pkg::word_t  w_i [16],
  input  logic [5:0]      rnd_i,
  output sha_pkg::state_t v_o,
  output sha_pkg::word_t  w_o [16]
);
  import sha_pkg::*;

  word_t e, a, big1, big0, ch, maj, t1, t2, x, y, s0, s1;

  function automatic word_t ror(word_t v, int n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

  always_comb begin
    e    = v_i[4];
    a    = v_i[0];
    big1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
    ch   = (e & v_i[5]) ^ (~e & v_i[6]);
    t1   = v_i[7] + big1 + ch + RoundK[rnd_i] + w_i[0];
    big0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
    maj  = (a & v_i[1]) ^ (a & v_i[2]) ^ (v_i[1] & v_i[2]);
    t2   = big0 + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
    // window slides: w[t+16] = s1(w[t+14]) + w[t+9] + s0(w[t+1]) + w[t]
    x  = w_i[1];
    y  = w_i[14];
    s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    s1 = ror(y, 17) ^ ror(y, 19) ^ (y >> 10);
    for (int i = 0; i < 15; i++) w_o[i] = w_i[i+1];
    w_o[15] = s1 + w_i[9] + s0 + w_i[0];
  end
endmodule

// ===== sv/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// SHA-256 over a byte stream. A data beat (command 0) leaves busy low, except the 64th
// byte of a block, which keeps busy high while one shared round unit runs the
// compression. A finish beat pads with zero bytes (up to 63) and the length, runs one
// or two compressions, then drives the eight digest words back to back with out_valid_o
// high; the receiver cannot stall them.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StPad, StLen, StComp, StOut
  } st_e;

  st_e         st_q;
  state_t      h_q, v_q, v_n;
  word_t       w_q [16];
  word_t       w_n [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic [2:0]  cnt_q;
  logic        fin_q;   // finish in progress
  logic        more_q;  // after this compression, another padding block follows
  logic        pad_only_q;

  sha_round u_round (.v_i(v_q), .w_i(w_q), .rnd_i(rnd_q), .v_o(v_n), .w_o(w_n));

  assign busy = (st_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      h_q         <= InitH;
      fill_q      <= '0;
      bits_q      <= '0;
      rnd_q       <= '0;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      more_q      <= 1'b0;
      pad_only_q  <= 1'b0;
      out_valid_o <= 1'b0;
      last_word_o <= 1'b0;
      word_index_o <= '0;
      digest_word_o <= '0;
    end else begin
      out_valid_o <= 1'b0;
      last_word_o <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (start) begin
            if (command_i == CmdAbsorb) begin
              w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= data_byte_i;
              fill_q <= fill_q + 6'd1;
              bits_q <= bits_q + 64'd8;
              if (fill_q == 6'd63) begin
                v_q   <= h_q;
                rnd_q <= '0;
                fin_q <= 1'b0;
                st_q  <= StComp;
              end
            end else begin
              w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= PadByte;
              fin_q  <= 1'b1;
              more_q <= (fill_q > 6'd55);
              fill_q <= fill_q + 6'd1;
              // pad byte at 55 leaves no zero bytes before the length
              st_q   <= (fill_q == 6'd63) ? StComp :
                        (fill_q == 6'd55) ? StLen : StPad;
              v_q    <= h_q;
              rnd_q  <= '0;
              pad_only_q <= (fill_q > 6'd55);
            end
          end
        end
        StPad: begin
          // zero bytes up to 55 (length block) or 63 (overflow block)
          w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= 8'h00;
          fill_q <= fill_q + 6'd1;
          if (!pad_only_q && fill_q == 6'd55) st_q <= StLen;
          else if (pad_only_q && fill_q == 6'd63) begin
            v_q <= h_q; rnd_q <= '0; st_q <= StComp;
          end
        end
        StLen: begin
          w_q[14] <= bits_q[63:32];
          w_q[15] <= bits_q[31:0];
          v_q     <= h_q;
          rnd_q   <= '0;
          more_q  <= 1'b0;
          st_q    <= StComp;
        end
        StComp: begin
          v_q   <= v_n;
          w_q   <= w_n;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_n[i];
            fill_q <= '0;
            if (!fin_q) st_q <= StIdle;
            else if (more_q) begin
              pad_only_q <= 1'b0;
              st_q <= StPad;
            end else begin
              cnt_q <= '0;
              st_q  <= StOut;
            end
          end
        end
        StOut: begin
          out_valid_o   <= 1'b1;
          digest_word_o <= h_q[cnt_q];
          word_index_o  <= cnt_q;
          last_word_o   <= (cnt_q == 3'd7);
          cnt_q         <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            h_q    <= InitH;
            bits_q <= '0;
            fill_q <= '0;
            fin_q  <= 1'b0;
            st_q   <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  a_out_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o |=> out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest words not consecutive");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last_word mismatch");
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o |-> busy)
    else $error("output while idle");
  a_comp_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StComp && rnd_q != 6'd63 |=> st_q == StComp)
    else $error("compression cut short");
endmodule
